FILE: hw/rtl/rstach_pkg.sv
// rstach_pkg: shared constants and types for the rotor speed tachometer.
// No dependencies; imported by rstach_div and rotor_speed_tachometer.
`timescale 1ns / 1ps

package rstach_pkg;

  localparam int TIME_W  = 48;
  localparam int CNT_W   = 32;
  localparam int VAL_W   = 31;
  localparam int MULT_W  = 4;
  localparam int TPM_W   = 32;
  localparam int CFG_D_W = 32;
  localparam int CFG_I_W = 1;
  localparam int LIM_W   = VAL_W + MULT_W;
  localparam int RPM_NUM_W = TPM_W + 1;

  localparam logic [VAL_W-1:0] MAX31 = {VAL_W{1'b1}};

  localparam logic [CFG_I_W-1:0] CFG_STOP_MULT = 1'b0;
  localparam logic [CFG_I_W-1:0] CFG_TICKS_PM  = 1'b1;

  // Item kinds carried on in_action.
  localparam logic ACT_MARKER = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [MULT_W-1:0] MULT_RESET = 4'd3;
  localparam logic [TPM_W-1:0]  TPM_RESET  = 32'd60000000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/rstach_div.sv
// rstach_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on rstach_pkg (div_stat_t).
`timescale 1ns / 1ps

module rstach_div
  import rstach_pkg::*;
#(
  parameter int N_W = 34,
  parameter int D_W = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [N_W-1:0] quot,
  output div_stat_t      stat
);

  localparam int C_W = $clog2(N_W + 1);

  logic [C_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [D_W:0]   rem_r, rem_nxt;
  logic [N_W-1:0] quo_r, quo_nxt;
  logic [D_W-1:0] den_r, den_nxt;

  logic [D_W:0]   rem_sh;
  logic           ge;

  assign rem_sh = {rem_r[D_W-1:0], quo_r[N_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt  = C_W'(N_W);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_nxt = {quo_r[N_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == C_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quot      = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == C_W'(N_W))
    else $error("divider did not load on start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a run");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("divider count left over while idle");

endmodule

FILE: hw/rtl/rotor_speed_tachometer.sv
// rotor_speed_tachometer: top level, sequencer, window store and output register.
// Depends on rstach_pkg and rstach_div.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    action, timestamp_us, revolution_count
//   out_     out  out_valid / out_ready  speed_rpm, speed_rpm_mean, period_ticks,
//                                        count_out, stopped
//   cfg_     in   cfg_we                 cfg_index, cfg_data (no read-back)
//
// Flow: a query passes S_EVAL and S_PUB. A marker that yields a speed passes
//   S_EVAL, S_DIV1, S_WIN1, S_WIN2, S_MEAN, S_DIV2 and S_PUB; S_DIV1 and S_DIV2
//   are the two passes of the shared bit-serial divider. A marker that restarts
//   the filter passes S_EVAL and S_PUB.
// Reset: synchronous, active low; clears control state and loads register
//   defaults. The window store needs no clearing: the fill count gates reads.
// Stalls: one item is in work at a time. A finished result sits in the output
//   register while the next transaction is accepted and worked on.
`timescale 1ns / 1ps

module rotor_speed_tachometer
  import rstach_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [TIME_W-1:0]  in_timestamp_us,
  input  logic [CNT_W-1:0]   in_revolution_count,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [VAL_W-1:0]   out_speed_rpm,
  output logic [VAL_W-1:0]   out_speed_rpm_mean,
  output logic [VAL_W-1:0]   out_period_ticks,
  output logic [VAL_W-1:0]   out_count_out,
  output logic               out_stopped,

  input  logic               cfg_we,
  input  logic [CFG_I_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data
);

  // Window sizing: the sum of DEPTH samples of 31 bits, fill counts 0..DEPTH.
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = VAL_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_W  = (SUM_W > RPM_NUM_W) ? SUM_W : RPM_NUM_W;

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a transaction
  localparam logic [2:0] S_EVAL = 3'd1;  // classify, restart or launch speed divide
  localparam logic [2:0] S_DIV1 = 3'd2;  // speed divide running
  localparam logic [2:0] S_WIN1 = 3'd3;  // retire oldest sample or grow fill
  localparam logic [2:0] S_WIN2 = 3'd4;  // store new sample, add into sum
  localparam logic [2:0] S_MEAN = 3'd5;  // launch mean divide
  localparam logic [2:0] S_DIV2 = 3'd6;  // mean divide running
  localparam logic [2:0] S_PUB  = 3'd7;  // load output register

  // Configuration registers
  logic [MULT_W-1:0] mult_r;
  logic [TPM_W-1:0]  tpm_r;

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic              seen_r, seen_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath state
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [VAL_W-1:0]  period_r, period_nxt;
  logic [VAL_W-1:0]  latest_r, latest_nxt;
  logic [VAL_W-1:0]  mean_r, mean_nxt;
  logic [VAL_W-1:0]  held_r, held_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              stale_r, stale_nxt;

  // Captured transaction and precomputed compare terms
  logic              act_r;
  logic [TIME_W-1:0] now_r;
  logic [CNT_W-1:0]  cnt_in_r;
  logic [TIME_W-1:0] gap_r;
  logic [LIM_W-1:0]  limit_r;

  // Output register payload
  logic [VAL_W-1:0]  o_speed_r, o_mean_r, o_period_r, o_count_r;
  logic              o_stop_r;

  // Window store
  logic [VAL_W-1:0]  win_mem [WINDOW_DEPTH];
  logic [VAL_W-1:0]  old_q_r;
  logic              win_we;

  // Divider hookup
  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [VAL_W-1:0]  div_den;
  logic [DIV_W-1:0]  div_quot;
  div_stat_t         div_stat;

  logic              accept;
  logic              stale_now;
  logic              bad_gap;
  logic              full;
  logic              stop_now;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign stale_now = gap_r > TIME_W'(limit_r);
  assign bad_gap   = (gap_r == '0) || (|gap_r[TIME_W-1:VAL_W]);
  assign full      = (fill_r == FILL_W'(WINDOW_DEPTH));
  // After a marker the own gap is zero, so only the query path can be stale.
  assign stop_now  = !seen_r || (period_r == '0) || stale_r;

  rstach_div #(
    .N_W (DIV_W),
    .D_W (VAL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Speed: (tpm + gap/2) / gap. Mean: (sum + fill/2) / fill.
  always_comb begin
    if (state_r == S_EVAL) begin
      div_num = DIV_W'({1'b0, tpm_r} + RPM_NUM_W'(gap_r[VAL_W-1:1]));
      div_den = gap_r[VAL_W-1:0];
    end else begin
      div_num = DIV_W'(sum_r) + DIV_W'(fill_r >> 1);
      div_den = VAL_W'(fill_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    last_time_nxt = last_time_r;
    period_nxt    = period_r;
    latest_nxt    = latest_r;
    mean_nxt      = mean_r;
    held_nxt      = held_r;
    sum_nxt       = sum_r;
    stale_nxt     = stale_r;
    div_start     = 1'b0;
    win_we        = 1'b0;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        stale_nxt = 1'b0;
        state_nxt = S_PUB;
        if (act_r == ACT_QUERY) begin
          stale_nxt = stale_now;
        end else begin
          held_nxt      = cnt_in_r[CNT_W-1] ? MAX31 : cnt_in_r[VAL_W-1:0];
          last_time_nxt = now_r;
          seen_nxt      = 1'b1;
          if (!seen_r || (period_r != '0 && stale_now) || bad_gap) begin
            // filter restart
            sum_nxt    = '0;
            fill_nxt   = '0;
            slot_nxt   = '0;
            latest_nxt = '0;
            mean_nxt   = '0;
            period_nxt = '0;
          end else begin
            period_nxt = gap_r[VAL_W-1:0];
            div_start  = 1'b1;
            state_nxt  = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_stat.done) begin
          latest_nxt = (|div_quot[DIV_W-1:VAL_W]) ? MAX31 : div_quot[VAL_W-1:0];
          state_nxt  = S_WIN1;
        end
      end
      S_WIN1: begin
        if (full) begin
          sum_nxt = sum_r - SUM_W'(old_q_r);
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = S_WIN2;
      end
      S_WIN2: begin
        win_we    = 1'b1;
        sum_nxt   = sum_r + SUM_W'(latest_r);
        slot_nxt  = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        div_start = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_stat.done) begin
          mean_nxt  = div_quot[VAL_W-1:0];
          state_nxt = S_PUB;
        end
      end
      S_PUB: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= 1'b0;
      fill_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      last_time_r <= '0;
      period_r    <= '0;
      latest_r    <= '0;
      mean_r      <= '0;
      held_r      <= '0;
      sum_r       <= '0;
      stale_r     <= 1'b0;
      mult_r      <= MULT_RESET;
      tpm_r       <= TPM_RESET;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      last_time_r <= last_time_nxt;
      period_r    <= period_nxt;
      latest_r    <= latest_nxt;
      mean_r      <= mean_nxt;
      held_r      <= held_nxt;
      sum_r       <= sum_nxt;
      stale_r     <= stale_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STOP_MULT: mult_r <= cfg_data[MULT_W-1:0];
          CFG_TICKS_PM:  tpm_r  <= cfg_data[TPM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Capture on accept; gap and stale limit are registered for the next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      now_r    <= in_timestamp_us;
      cnt_in_r <= in_revolution_count;
      gap_r    <= in_timestamp_us - last_time_r;
      limit_r  <= LIM_W'(period_r) * LIM_W'(mult_r);
    end
  end

  // Window store: one write port, registered read at the current slot.
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[slot_r] <= latest_r;
    end
    old_q_r <= win_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUB && (!out_valid_r || out_ready)) begin
      o_speed_r  <= stop_now ? '0 : latest_r;
      o_mean_r   <= stop_now ? '0 : mean_r;
      o_period_r <= stop_now ? '0 : period_r;
      o_count_r  <= held_r;
      o_stop_r   <= stop_now;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_speed_rpm      = o_speed_r;
  assign out_speed_rpm_mean = o_mean_r;
  assign out_period_ticks   = o_period_r;
  assign out_count_out      = o_count_r;
  assign out_stopped        = o_stop_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EVAL)
    else $error("accepted transaction did not start work");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill above depth");

  a_unseen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> period_r == '0 && fill_r == '0)
    else $error("filter state without a marker");

  a_stop_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_stop_r |-> o_speed_r == '0 && o_mean_r == '0 && o_period_r == '0)
    else $error("stopped result carries speed data");

  a_run_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_stop_r |-> o_period_r != '0)
    else $error("running result with zero period");

endmodule

FILE: test/rotor_speed_tachometer_test.sv
// rotor_speed_tachometer_test: self-checking testbench for rotor_speed_tachometer.
// Depends on rstach_pkg and the rotor_speed_tachometer RTL; uses a built-in snapshot
// predictor, directed period/window cases and random marker/query traffic under idling.
`timescale 1ns / 1ps

module rotor_speed_tachometer_test
  import rstach_pkg::*;
();

  // Window depth of the instance; the predictor ring uses the same size.
  localparam int RING_DEPTH = 8;

  // One snapshot as the block returns it.
  typedef struct {
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] count;
    logic             stopped;
  } snapshot_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic [TIME_W-1:0]  in_timestamp_us;
  logic [CNT_W-1:0]   in_revolution_count;
  logic               out_valid;
  logic               out_ready;
  logic [VAL_W-1:0]   out_speed_rpm;
  logic [VAL_W-1:0]   out_speed_rpm_mean;
  logic [VAL_W-1:0]   out_period_ticks;
  logic [VAL_W-1:0]   out_count_out;
  logic               out_stopped;
  logic               cfg_we;
  logic [CFG_I_W-1:0] cfg_index;
  logic [CFG_D_W-1:0] cfg_data;

  rotor_speed_tachometer #(
    .WINDOW_DEPTH(RING_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_timestamp_us     (in_timestamp_us),
    .in_revolution_count (in_revolution_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_speed_rpm       (out_speed_rpm),
    .out_speed_rpm_mean  (out_speed_rpm_mean),
    .out_period_ticks    (out_period_ticks),
    .out_count_out       (out_count_out),
    .out_stopped         (out_stopped),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Snapshots predicted for accepted transactions, oldest first.
  snapshot_t pending_snapshots[$];
  int unsigned error_count;

  // Idle knobs, in percent per cycle.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Stimulus cursors carried from one traffic phase to the next.
  logic [TIME_W-1:0] stamp_cursor;
  logic [CNT_W-1:0]  count_cursor;

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the tachometer; samples kept at the block's widths.
  // ---------------------------------------------------------------------------
  logic [MULT_W-1:0] stop_mult;
  logic [TPM_W-1:0]  ticks_pm;
  logic              have_marker;
  logic [TIME_W-1:0] prev_marker_stamp;
  logic [VAL_W-1:0]  period_hold;
  logic [VAL_W-1:0]  rpm_now;
  logic [VAL_W-1:0]  rpm_avg;
  logic [VAL_W-1:0]  count_hold;
  logic [VAL_W-1:0]  rpm_ring [RING_DEPTH];
  logic [63:0]       ring_sum;
  int unsigned       ring_fill;
  int unsigned       ring_pos;

  // Filter restart: window, averages and period all go back to zero.
  task automatic clear_average();
    for (int k = 0; k < RING_DEPTH; k++) rpm_ring[k] = '0;
    ring_sum    = '0;
    ring_fill   = 0;
    ring_pos    = 0;
    rpm_now     = '0;
    rpm_avg     = '0;
    period_hold = '0;
  endtask

  // Gap is stale once it runs past multiplier times the last period.
  function automatic bit gap_exceeds_limit(input logic [TIME_W-1:0] gap);
    return 64'(gap) > 64'(period_hold) * 64'(stop_mult);
  endfunction

  task automatic take_revolution(input logic [TIME_W-1:0] stamp,
                                 input logic [CNT_W-1:0] cnt);
    logic [TIME_W-1:0] gap;
    logic [63:0]       rpm;
    count_hold = (cnt > CNT_W'(MAX31)) ? MAX31 : cnt[VAL_W-1:0];
    if (!have_marker) begin
      have_marker       = 1'b1;
      prev_marker_stamp = stamp;
      clear_average();
      return;
    end
    // Time wraps at 48 bits, so a backwards stamp turns into a huge gap.
    gap               = stamp - prev_marker_stamp;
    prev_marker_stamp = stamp;
    if ((period_hold != '0 && gap_exceeds_limit(gap)) || gap == '0 ||
        gap > TIME_W'(MAX31)) begin
      clear_average();
      return;
    end
    rpm         = (64'(ticks_pm) + 64'(gap >> 1)) / 64'(gap);
    period_hold = gap[VAL_W-1:0];
    rpm_now     = (rpm > 64'(MAX31)) ? MAX31 : rpm[VAL_W-1:0];
    // Ring window: once full, the oldest sample drops out of the sum.
    if (ring_fill >= RING_DEPTH) ring_sum -= 64'(rpm_ring[ring_pos]);
    else ring_fill++;
    rpm_ring[ring_pos] = rpm_now;
    ring_sum += 64'(rpm_now);
    ring_pos = (ring_pos + 1) % RING_DEPTH;
    rpm_avg  = VAL_W'((ring_sum + 64'(ring_fill / 2)) / 64'(ring_fill));
  endtask

  task automatic predict_snapshot(input logic act, input logic [TIME_W-1:0] stamp,
                                  input logic [CNT_W-1:0] cnt, output snapshot_t snap);
    logic [TIME_W-1:0] gap;
    logic              halted;
    if (act == ACT_MARKER) take_revolution(stamp, cnt);
    // Staleness is judged from the item's own stamp, queries included.
    gap          = stamp - prev_marker_stamp;
    halted       = !have_marker || period_hold == '0 || gap_exceeds_limit(gap);
    snap.speed   = halted ? '0 : rpm_now;
    snap.mean    = halted ? '0 : rpm_avg;
    snap.period  = halted ? '0 : period_hold;
    snap.count   = count_hold;
    snap.stopped = halted;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver and result checking
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls at random; the knob is set per phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
  endtask

  // Values read here are the pre-edge ones, so the handshake is seen as the DUT sees it.
  always @(posedge clk) begin : check_results
    snapshot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_snapshots.size() == 0) begin
        report_mismatch("result transaction with no snapshot outstanding");
      end else begin
        want = pending_snapshots.pop_front();
        check_field("speed_rpm", out_speed_rpm, want.speed);
        check_field("speed_rpm_mean", out_speed_rpm_mean, want.mean);
        check_field("period_ticks", out_period_ticks, want.period);
        check_field("count_out", out_count_out, want.count);
        check_field("stopped", VAL_W'(out_stopped), VAL_W'(want.stopped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drive helpers
  // ---------------------------------------------------------------------------

  // Sends one item. Valid stays high on return so back-to-back items need no
  // second assignment in the same step; idle cycles lower it first.
  task automatic send_item(input logic act, input logic [TIME_W-1:0] stamp,
                           input logic [CNT_W-1:0] cnt);
    snapshot_t snap;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= act;
    in_timestamp_us     <= stamp;
    in_revolution_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_snapshot(act, stamp, cnt, snap);
    pending_snapshots.push_back(snap);
  endtask

  // Every item gives a result, so the block is idle once the queue is empty.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_snapshots.size() != 0);
  endtask

  // Both registers back to back; call only while drained.
  task automatic program_registers(input logic [CFG_D_W-1:0] mult_data,
                                   input logic [CFG_D_W-1:0] tpm_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STOP_MULT;
    cfg_data  <= mult_data;
    @(posedge clk);
    cfg_index <= CFG_TICKS_PM;
    cfg_data  <= tpm_data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stop_mult = mult_data[MULT_W-1:0];
    ticks_pm  = tpm_data[TPM_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: stopped until two markers, staleness boundary at 3 periods.
  task automatic test_reset_snapshot();
    send_item(ACT_QUERY, 48'd0, 32'hFFFF_FFFF);    // nothing seen yet, count ignored
    send_item(ACT_MARKER, 48'd100, 32'hFFFF_FFFF); // first marker, count saturates
    send_item(ACT_MARKER, 48'd1100, 32'd7);        // period 1000 -> 60000 rpm
    send_item(ACT_QUERY, 48'd4100, 32'd0);         // exactly at the limit, still live
    send_item(ACT_QUERY, 48'd4101, 32'd0);         // one past, stopped
    send_item(ACT_MARKER, 48'd4101, 32'd8);        // stale marker restarts the filter
  endtask

  // Zero, oversized, maximum and wrapped periods.
  task automatic test_period_edges();
    logic [TIME_W-1:0] t;
    t = 48'd4101;
    send_item(ACT_MARKER, t, 32'd9);               // zero gap
    t = t + 48'h8000_0000;
    send_item(ACT_MARKER, t, 32'd10);              // gap above 31 bits
    t = t + TIME_W'(MAX31);
    send_item(ACT_MARKER, t, 32'd11);              // largest legal period, speed rounds to 0
    send_item(ACT_MARKER, t - 48'd1, 32'd12);      // backwards stamp -> huge gap
    send_item(ACT_MARKER, 48'hFFFF_FFFF_FFF0, 32'h8000_0000);
    send_item(ACT_MARKER, 48'h10, 32'h7FFF_FFFF);  // gap across the 48-bit wrap
    send_item(ACT_MARKER, 48'h30, 32'h7FFF_FFFE);
    send_item(ACT_QUERY, 48'hFFFF_FFFF_FFFF, 32'd0);
  endtask

  // Largest numerator: speed saturates, then the ring rolls over.
  task automatic test_saturation_window();
    logic [TIME_W-1:0] t;
    wait_until_drained();
    program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF); // upper junk bits must be dropped
    t = 48'h1000;
    send_item(ACT_MARKER, t, 32'd20);              // stale vs old period, restart
    for (int g = 1; g <= 10; g++) begin
      t = t + TIME_W'(g);
      send_item(ACT_MARKER, t, 32'd20 + CNT_W'(g));
    end
  endtask

  // Multiplier and numerator at zero.
  task automatic test_register_extremes();
    logic [TIME_W-1:0] t;
    wait_until_drained();
    program_registers(32'hFFFF_FFF0, 32'd0);
    t = 48'h2000;
    send_item(ACT_MARKER, t, 32'd40);              // any nonzero gap is stale now
    t = t + 48'd5;
    send_item(ACT_MARKER, t, 32'd41);              // no period held, so accepted; speed 0
    send_item(ACT_QUERY, t, 32'd0);                // zero gap, live with speed 0
    send_item(ACT_QUERY, t + 48'd1, 32'd0);        // stale
    send_item(ACT_MARKER, t + 48'd1, 32'd42);      // stale marker restarts
    wait_until_drained();
  endtask

  // Runs of markers at a jittered nominal period with queries in between;
  // a minority of markers are zero, backwards, oversized or stale gaps.
  task automatic test_random_traffic(input int unsigned n_items);
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] delta;
    logic [CNT_W-1:0]  cnt;
    int unsigned       sent;
    int unsigned       nominal;
    int unsigned       run_len;
    int unsigned       roll;
    t    = stamp_cursor;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) t = {16'($urandom()), $urandom()};
      case ($urandom_range(7))
        0:       nominal = $urandom_range(1, 16);
        1:       nominal = $urandom_range(32'h0010_0000, 32'h4000_0000);
        default: nominal = $urandom_range(50, 100000);
      endcase
      run_len = $urandom_range(2, 20);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        roll = $urandom_range(99);
        if (roll < 4)       delta = '0;
        else if (roll < 7)  delta = '0 - TIME_W'($urandom_range(1, 100000));
        else if (roll < 10) delta = 48'h8000_0000 + TIME_W'($urandom());
        else if (roll < 14) delta = TIME_W'(nominal) * (TIME_W'(stop_mult) + 48'd1)
                                    + TIME_W'($urandom_range(1, 1000));
        else                delta = TIME_W'(nominal - nominal / 16
                                    + $urandom_range(0, nominal / 8));
        t = t + delta;
        roll = $urandom_range(99);
        if (roll < 10)      count_cursor = $urandom();
        else if (roll < 15) count_cursor = 32'h7FFF_FFFF - CNT_W'($urandom_range(0, 3));
        else                count_cursor = count_cursor + 32'd1;
        send_item(ACT_MARKER, t, count_cursor);
        sent++;
        if ($urandom_range(99) < 30 && sent < n_items) begin
          cnt = $urandom();
          send_item(ACT_QUERY,
                    t + TIME_W'($urandom_range(0, nominal)) * TIME_W'($urandom_range(0, 4)),
                    cnt);
          sent++;
        end
        // Occasionally let the pipeline empty completely mid-stream.
        if ($urandom_range(199) == 0) wait_until_drained();
      end
    end
    stamp_cursor = t;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_action           = ACT_MARKER;
    in_timestamp_us     = '0;
    in_revolution_count = '0;
    out_ready           = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_STOP_MULT;
    cfg_data            = '0;
    error_count         = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    stamp_cursor        = 48'h0000_0001_0000;
    count_cursor        = '0;

    // Predictor matches the block's reset.
    stop_mult         = MULT_RESET;
    ticks_pm          = TPM_RESET;
    have_marker       = 1'b0;
    prev_marker_stamp = '0;
    count_hold        = '0;
    clear_average();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_snapshot();
    test_period_edges();
    test_saturation_window();
    test_register_extremes();

    // Phase 1: no idling, reset settings.
    program_registers(32'd3, 32'd60000000);
    test_random_traffic(270);
    wait_until_drained();

    // Phase 2: sender mostly idle, top multiplier and numerator.
    send_idle_pct  = 78;
    recv_stall_pct = 0;
    program_registers(32'd15, 32'hFFFF_FFFF);
    test_random_traffic(270);
    wait_until_drained();

    // Phase 3: receiver mostly stalled, multiplier of one.
    send_idle_pct  = 0;
    recv_stall_pct = 78;
    program_registers(32'd1, $urandom_range(1000, 32'hFFFF_FFFF));
    test_random_traffic(270);
    wait_until_drained();

    // Phase 4: both sides idle now and then, random settings.
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    program_registers({28'($urandom_range(32'h0FFF_FFFF)), 4'($urandom_range(2, 14))},
                      $urandom());
    test_random_traffic(270);
    wait_until_drained();

    // Tail: room for a stray late result.
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a hung run ends with an error report.
  initial begin
    #1500000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
